@@ rtl/core/svcc_pkg.sv @@
// Shared types and constants for the solenoid valve command controller.
// No dependencies.
package svcc_pkg;

	localparam int PORTS_DEF  = 8;
	localparam int VALVE_W    = 8;
	localparam int PORT_NUM_W = 3;
	localparam int MODE_W     = 3;

	localparam logic [VALVE_W-1:0] VALVE_RESET = 8'h00;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE_BYTE = 3'd0,
		MODE_WRITE_BIT  = 3'd1,
		MODE_INVERT_ALL = 3'd2,
		MODE_INVERT_BIT = 3'd3,
		MODE_PRESS      = 3'd4,
		MODE_TIMED      = 3'd5,
		MODE_DOUBLE     = 3'd6
	} mode_t;

endpackage

@@ rtl/core/solenoid_valve_command_controller_unit.sv @@
// Solenoid valve command controller, top level.
// Depends on svcc_pkg.
//
// Path: stage 1 registers the accepted command, then the output slot its result.
// Throughput: one command per cycle while the output drains; the input register and
// valve state update form one read-modify-write of the valve byte and armed flags.
// Reset (arst_n low, async): valve byte 0x00, every port armed, pipeline empty.
module solenoid_valve_command_controller_unit #(
	parameter int PORTS = svcc_pkg::PORTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [svcc_pkg::MODE_W-1:0]     mode,
	input  logic [svcc_pkg::PORT_NUM_W-1:0] port_a,
	input  logic [svcc_pkg::PORT_NUM_W-1:0] port_b,
	input  logic                            level,
	input  logic [svcc_pkg::VALVE_W-1:0]    value,
	input  logic                            timer_done,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [svcc_pkg::VALVE_W-1:0]    valve_bits,
	output logic                            timer_flag_out
);
	import svcc_pkg::*;

	// Index width into the armed flags; port numbers are range checked first.
	localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam logic [PORT_NUM_W:0] PORT_LIM = (PORT_NUM_W+1)'(PORTS);
	// Only the low PORTS bits of the valve byte ever carry a coil.
	localparam logic [VALVE_W-1:0] PORT_MASK = VALVE_W'((9'd1 << PORTS) - 9'd1);

	// Stage 1: registered command transaction.
	logic                  valid_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic [PORT_NUM_W-1:0] port_a_s1;
	logic [PORT_NUM_W-1:0] port_b_s1;
	logic                  level_s1;
	logic [VALVE_W-1:0]    value_s1;
	logic                  timer_done_s1;

	// Block state. The valve byte doubles as the result byte: it only changes
	// when a new result is loaded into the output slot.
	logic [VALVE_W-1:0]    valve_q;
	logic [PORTS-1:0]      armed_q;
	logic                  out_valid_q;
	logic                  timer_out_q;

	logic                  advance;
	logic                  a_ok;
	logic                  b_ok;
	logic [IDX_W-1:0]      ia;
	logic [IDX_W-1:0]      ib;
	logic [VALVE_W-1:0]    valve_nxt;
	logic [PORTS-1:0]      armed_nxt;
	logic                  timer_nxt;

	// Stage 1 retires into the output slot when that slot is free or drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid      = out_valid_q;
	assign valve_bits     = valve_q;
	assign timer_flag_out = timer_out_q;

	assign a_ok = {1'b0, port_a_s1} < PORT_LIM;
	assign b_ok = {1'b0, port_b_s1} < PORT_LIM;
	assign ia   = port_a_s1[IDX_W-1:0];
	assign ib   = port_b_s1[IDX_W-1:0];

	// Command decode. Blocking updates in model order so that equal coil ports
	// in double valve mode see each earlier update.
	always_comb begin
		valve_nxt = valve_q;
		armed_nxt = armed_q;
		timer_nxt = timer_done_s1;
		unique case (mode_s1) inside
			MODE_WRITE_BYTE: begin
				valve_nxt = value_s1 & PORT_MASK;
			end
			MODE_WRITE_BIT: begin
				if (a_ok) valve_nxt[port_a_s1] = level_s1;
			end
			MODE_INVERT_ALL: begin
				valve_nxt = ~valve_q & PORT_MASK;
			end
			MODE_INVERT_BIT: begin
				if (a_ok) valve_nxt[port_a_s1] = !valve_q[port_a_s1];
			end
			MODE_PRESS, MODE_TIMED: begin
				if (a_ok) begin
					if (level_s1) begin
						// Toggle on the press edge; timed mode also waits on the timer.
						if (armed_q[ia] && (mode_s1 == MODE_PRESS || timer_done_s1))
							valve_nxt[port_a_s1] = !valve_q[port_a_s1];
						armed_nxt[ia] = 1'b0;
					end else begin
						armed_nxt[ia] = 1'b1;
					end
				end
			end
			MODE_DOUBLE: begin
				if (a_ok && b_ok) begin
					if (level_s1) begin
						// Press: drop the active coil, restart dead time if the opposite coil was on.
						if (armed_nxt[ia]) begin
							if (armed_nxt[ib]) begin
								if (valve_nxt[port_b_s1]) timer_nxt = 1'b0;
								valve_nxt[port_a_s1] = 1'b0;
							end else begin
								if (valve_nxt[port_a_s1]) timer_nxt = 1'b0;
								valve_nxt[port_b_s1] = 1'b0;
							end
						end
					end else if (armed_nxt[ia]) begin
						// Release: once both coils are off and dead time is over,
						// energize the opposite coil and flip direction.
						if (!(valve_nxt[port_a_s1] || valve_nxt[port_b_s1] ||
							!timer_done_s1)) begin
							if (armed_nxt[ib]) valve_nxt[port_b_s1] = 1'b1;
							else               valve_nxt[port_a_s1] = 1'b1;
							armed_nxt[ia] = 1'b0;
							armed_nxt[ib] = !armed_nxt[ib];
						end
					end else begin
						armed_nxt[ia] = 1'b1;
					end
				end
			end
			default: begin
				// Undefined mode: state holds, timer_done passes through.
			end
		endcase
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			valve_q     <= VALVE_RESET;
			armed_q     <= '1;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= 1'b1;
				valve_q     <= valve_nxt;
				armed_q     <= armed_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1       <= mode;
			port_a_s1     <= port_a;
			port_b_s1     <= port_b;
			level_s1      <= level;
			value_s1      <= value;
			timer_done_s1 <= timer_done;
		end
		if (advance) timer_out_q <= timer_nxt;
	end

	// Coil bits above the port count never turn on.
	a_unused_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valve_q & ~PORT_MASK) == '0)
		else $error("valve bit above port count set");

	// A stalled stage-1 transaction is not lost.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stage 1 transaction dropped");

	// Only double valve mode may clear the timer flag.
	a_timer_pass: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 != MODE_DOUBLE |=> timer_flag_out == $past(timer_done_s1))
		else $error("timer flag changed outside double valve mode");

	// Write byte loads the masked value.
	a_write_byte: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 == MODE_WRITE_BYTE |=> valve_q == ($past(value_s1) & PORT_MASK))
		else $error("write byte mismatch");

	// An empty output slot never blocks the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output");

endmodule
